// ===== design/text_screen_cursor_buffer_top_assert.svh =====
// assertion macros for the text screen cursor buffer
// used by text_screen_cursor_buffer_top, no other dependencies
`ifndef TEXT_SCREEN_CURSOR_BUFFER_TOP_ASSERT_SVH
`define TEXT_SCREEN_CURSOR_BUFFER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TSCB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TSCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tscb_pkg.sv =====
// shared types and constants of the text screen cursor buffer
// no dependencies
package tscb_pkg;

    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 64;

    localparam int ACTION_W = 4;
    localparam int TROW_W   = 6;
    localparam int TCOL_W   = 7;
    localparam int CHAR_W   = 8;
    localparam int LEN_W    = 7;
    localparam int POS_W    = 11;

    localparam int CFG_ROWS_W = 6;
    localparam int CFG_COLS_W = 7;
    localparam int CFG_DATA_W = 7;

    // geometry fields sized for the largest legal MAX_ROWS / MAX_COLS (256)
    localparam int GEOM_DIM_W  = 9;
    localparam int GEOM_SIZE_W = 17;

    localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 6'd24;
    localparam logic [CFG_COLS_W-1:0] COLS_RESET = 7'd64;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h58;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    typedef enum logic [0:0] {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

    typedef enum logic [ACTION_W-1:0] {
        ACT_HOME    = 4'd0,
        ACT_FWD     = 4'd1,
        ACT_BACK    = 4'd2,
        ACT_UP      = 4'd3,
        ACT_DOWN    = 4'd4,
        ACT_END     = 4'd5,
        ACT_MOVE    = 4'd6,
        ACT_WRITE   = 4'd7,
        ACT_READPOS = 4'd8,
        ACT_READ    = 4'd9,
        ACT_CLEAR   = 4'd10,
        ACT_SQUARE  = 4'd11
    } t_action;

    typedef struct packed {
        logic [GEOM_DIM_W-1:0]  rows;
        logic [GEOM_DIM_W-1:0]  cols;
        logic [GEOM_SIZE_W-1:0] size;
    } t_geom;

endpackage

// ===== design/tscb_ifs.sv =====
// command and response channels of the text screen cursor buffer
// depends on tscb_pkg
interface tscb_cmd_if import tscb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [TROW_W-1:0]   target_row;
    logic [TCOL_W-1:0]   target_col;
    logic [CHAR_W-1:0]   char_value;
    logic [LEN_W-1:0]    side_length;

    modport source (output valid, action, target_row, target_col, char_value, side_length,
                    input ready);
    modport sink (input valid, action, target_row, target_col, char_value, side_length,
                  output ready);
endinterface

interface tscb_rsp_if import tscb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] read_char;
    logic [POS_W-1:0]  cursor_pos;
    logic              error_flag;

    modport source (output valid, read_char, cursor_pos, error_flag, input ready);
    modport sink (input valid, read_char, cursor_pos, error_flag, output ready);
endinterface

// ===== design/tscb_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module tscb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/tscb_geom.sv =====
// screen geometry: row and column registers, clamping, registered area size
// depends on tscb_pkg
module tscb_geom import tscb_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_geom                 o_geom
);
    logic [CFG_ROWS_W-1:0]  r_rows;
    logic [CFG_COLS_W-1:0]  r_cols;
    logic [GEOM_SIZE_W-1:0] r_size;
    logic [GEOM_DIM_W-1:0]  rows_used;
    logic [GEOM_DIM_W-1:0]  cols_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
            r_cols <= COLS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROWS: r_rows <= i_cfg_data[CFG_ROWS_W-1:0];
                CFG_COLS: r_cols <= i_cfg_data[CFG_COLS_W-1:0];
                default:  r_rows <= r_rows;
            endcase
        end
    end

    // clamp to 1..max
    always_comb begin
        if (r_rows == '0) begin
            rows_used = GEOM_DIM_W'(1);
        end else if (GEOM_DIM_W'(r_rows) > GEOM_DIM_W'(MAX_ROWS)) begin
            rows_used = GEOM_DIM_W'(MAX_ROWS);
        end else begin
            rows_used = GEOM_DIM_W'(r_rows);
        end
        if (r_cols == '0) begin
            cols_used = GEOM_DIM_W'(1);
        end else if (GEOM_DIM_W'(r_cols) > GEOM_DIM_W'(MAX_COLS)) begin
            cols_used = GEOM_DIM_W'(MAX_COLS);
        end else begin
            cols_used = GEOM_DIM_W'(r_cols);
        end
    end

    always_ff @(posedge i_clk) begin
        r_size <= GEOM_SIZE_W'(rows_used) * GEOM_SIZE_W'(cols_used);
    end

    assign o_geom.rows = rows_used;
    assign o_geom.cols = cols_used;
    assign o_geom.size = r_size;
endmodule

// ===== design/text_screen_cursor_buffer_top.sv =====
// top level of the text screen cursor buffer: command sequencer around the cell ram
// depends on tscb_pkg, tscb_ifs, tscb_ram, tscb_geom and the assertion header
//
// Character screen of MAX_ROWS x MAX_COLS cells held in one synchronous ram, with a
// linear cursor. Each command word on i_cmd produces exactly one response word on
// o_rsp carrying the cell under the cursor, the cursor index and an error flag.
// Commands are handled one at a time: cursor motion, move, read and readpos go
// through the load, prep, exec and read states, and a write adds a write state. A clear
// fills the whole ram, one cell per cycle; a square writes its outline one cell per
// cycle in four runs of side_length cells. The single ram write port sets this rate.
// After reset the block runs a clearing pass over all MAX_ROWS*MAX_COLS cells that
// fills the ram with spaces and holds i_cmd.ready low; configuration writes are taken
// during it. The response sits in an output register, so the next command is taken
// while it waits.
`include "text_screen_cursor_buffer_top_assert.svh"

module text_screen_cursor_buffer_top import tscb_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tscb_cmd_if.sink              i_cmd,
    tscb_rsp_if.source            o_rsp
);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // cursor arithmetic must hold the area size itself
    localparam int SW    = $clog2(DEPTH + 1);
    localparam int CLW   = $clog2(MAX_COLS + 1);
    localparam int PW    = TROW_W + CLW;
    localparam int CKW   = 10;

    typedef enum logic [8:0] {
        S_INIT = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_LOAD = 9'b000000100,
        S_PREP = 9'b000001000,
        S_EXEC = 9'b000010000,
        S_WR   = 9'b000100000,
        S_CLR  = 9'b001000000,
        S_SQ   = 9'b010000000,
        S_RD   = 9'b100000000
    } t_state;

    t_geom geom;

    t_state              r_state, n_state;
    logic                r_rdw, n_rdw;
    logic [ACTION_W-1:0] r_act;
    logic [TROW_W-1:0]   r_trow;
    logic [TCOL_W-1:0]   r_tcol;
    logic [CHAR_W-1:0]   r_ch;
    logic [LEN_W-1:0]    r_len;
    logic [SW-1:0]       r_lin, n_lin;
    logic [SW-1:0]       r_cur, n_cur;
    logic [SW-1:0]       r_addr, n_addr;
    logic [SW-1:0]       r_br, n_br;
    logic [LEN_W-1:0]    r_cnt, n_cnt;
    logic [1:0]          r_phase, n_phase;
    logic [CHAR_W-1:0]   r_fill_ch, n_fill_ch;
    logic                r_err, n_err;

    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_o_char;
    logic [POS_W-1:0]    r_o_pos;
    logic                r_o_err;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr;
    logic [CHAR_W-1:0]   mem_wdata;
    logic [CHAR_W-1:0]   mem_rdata;

    logic [SW-1:0]       size_s, cols_s;
    logic [CKW-1:0]      rows_k, cols_k, trow_k, tcol_k, len_k;
    logic                in_rng, sq_ok, out_free, load_out;
    logic [TROW_W-1:0]   trow_m1;
    logic [TCOL_W-1:0]   tcol_m1;
    logic [PW-1:0]       lin_prod;

    tscb_geom #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom)
    );

    tscb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // up from the top row: bottom row, one column right; top-right goes bottom-left
    function automatic logic [SW-1:0] step_up(input logic [SW-1:0] c,
                                              input logic [SW-1:0] sz,
                                              input logic [SW-1:0] cl);
        logic [SW-1:0] res;
        if (c < cl) begin
            res = (c < cl - SW'(1)) ? (sz - cl + c + SW'(1)) : (sz - cl);
        end else begin
            res = c - cl;
        end
        return res;
    endfunction

    // down from the bottom row: top row, one column right; last cell goes to 0
    function automatic logic [SW-1:0] step_down(input logic [SW-1:0] c,
                                                input logic [SW-1:0] sz,
                                                input logic [SW-1:0] cl);
        logic [SW-1:0] res;
        if (c >= sz - cl) begin
            res = (c < sz - SW'(1)) ? (c + SW'(1) - (sz - cl)) : '0;
        end else begin
            res = c + cl;
        end
        return res;
    endfunction

    assign size_s = SW'(geom.size);
    assign cols_s = SW'(geom.cols);
    assign rows_k = CKW'(geom.rows);
    assign cols_k = CKW'(geom.cols);
    assign trow_k = CKW'(r_trow);
    assign tcol_k = CKW'(r_tcol);
    assign len_k  = CKW'(r_len);

    assign in_rng = (r_trow != '0) && (trow_k <= rows_k) &&
                    (r_tcol != '0) && (tcol_k <= cols_k);
    assign sq_ok  = (r_len != '0) && in_rng &&
                    (trow_k + len_k - CKW'(1) <= rows_k) &&
                    (tcol_k + len_k - CKW'(1) <= cols_k);

    // linear index of (target_row, target_col), only used when in range
    assign trow_m1  = r_trow - TROW_W'(1);
    assign tcol_m1  = r_tcol - TCOL_W'(1);
    assign lin_prod = PW'(trow_m1) * PW'(geom.cols);

    assign out_free = !r_out_valid || o_rsp.ready;
    assign load_out = r_rdw && out_free;

    always_comb begin
        n_state   = r_state;
        n_lin     = r_lin;
        n_cur     = r_cur;
        n_addr    = r_addr;
        n_br      = r_br;
        n_cnt     = r_cnt;
        n_phase   = r_phase;
        n_fill_ch = r_fill_ch;
        n_err     = r_err;
        n_rdw     = r_rdw && !out_free;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_addr[AW-1:0];
        mem_wdata = r_fill_ch;

        case (r_state)
            S_INIT, S_CLR: begin
                mem_we = 1'b1;
                n_addr = r_addr + SW'(1);
                if (r_addr == SW'(DEPTH - 1)) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_RD;
                end
            end
            S_IDLE: begin
                // a word is only taken once the previous response has moved into the output register
                if (i_cmd.valid && !r_rdw) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_lin   = SW'(lin_prod + PW'(tcol_m1));
                n_state = S_PREP;
            end
            S_PREP: begin
                // area may have shrunk under the cursor
                if (r_cur >= size_s) begin
                    n_cur = '0;
                end
                n_err   = 1'b0;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_RD;
                case (t_action'(r_act))
                    ACT_HOME: n_cur = '0;
                    ACT_FWD:  n_cur = (r_cur + SW'(1) >= size_s) ? '0 : r_cur + SW'(1);
                    ACT_BACK: n_cur = (r_cur == '0) ? size_s - SW'(1) : r_cur - SW'(1);
                    ACT_UP:   n_cur = step_up(r_cur, size_s, cols_s);
                    ACT_DOWN: n_cur = step_down(r_cur, size_s, cols_s);
                    ACT_END:  n_cur = size_s - SW'(1);
                    ACT_MOVE, ACT_READPOS: begin
                        if (in_rng) begin
                            n_cur = r_lin;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    ACT_WRITE: begin
                        if (r_ch == CH_NUL) begin
                            n_err = 1'b1;
                        end else begin
                            n_state = S_WR;
                        end
                    end
                    ACT_READ: n_state = S_RD;
                    ACT_CLEAR: begin
                        n_cur     = '0;
                        n_addr    = '0;
                        n_fill_ch = r_ch;
                        n_state   = S_CLR;
                    end
                    ACT_SQUARE: begin
                        if (sq_ok) begin
                            n_addr  = r_lin;
                            n_cnt   = r_len;
                            n_phase = 2'd0;
                            n_state = S_SQ;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    default: n_err = 1'b1;
                endcase
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cur[AW-1:0];
                mem_wdata = r_ch;
                n_state   = S_RD;
            end
            S_SQ: begin
                // outline in four runs: top right-ward, left down, bottom right-ward, right up
                mem_we    = 1'b1;
                mem_wdata = CH_X;
                n_cnt     = r_cnt - LEN_W'(1);
                if (r_cnt == LEN_W'(1)) begin
                    n_cnt   = r_len;
                    n_phase = r_phase + 2'd1;
                    case (r_phase)
                        2'd0: n_addr = r_lin;
                        2'd1: n_addr = r_addr;
                        2'd2: n_br   = r_addr;
                        default: begin
                            n_cur   = step_down(r_br, size_s, cols_s);
                            n_state = S_RD;
                        end
                    endcase
                end else begin
                    case (r_phase)
                        2'd0:    n_addr = r_addr + SW'(1);
                        2'd1:    n_addr = r_addr + cols_s;
                        2'd2:    n_addr = r_addr + SW'(1);
                        default: n_addr = r_addr - cols_s;
                    endcase
                end
            end
            S_RD: begin
                // ram read issued here, data lands while the response waits for room
                if (!r_rdw || out_free) begin
                    mem_re  = 1'b1;
                    n_rdw   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_cmd.ready = (r_state == S_IDLE) && !r_rdw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_cur       <= '0;
            r_fill_ch   <= CH_SPACE;
            r_rdw       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_cur     <= n_cur;
            r_fill_ch <= n_fill_ch;
            r_rdw     <= n_rdw;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lin   <= n_lin;
        r_br    <= n_br;
        r_cnt   <= n_cnt;
        r_phase <= n_phase;
        r_err   <= n_err;
        if (i_cmd.valid && i_cmd.ready) begin
            r_act  <= i_cmd.action;
            r_trow <= i_cmd.target_row;
            r_tcol <= i_cmd.target_col;
            r_ch   <= i_cmd.char_value;
            r_len  <= i_cmd.side_length;
        end
        if (load_out) begin
            r_o_char <= mem_rdata;
            r_o_pos  <= POS_W'(r_cur);
            r_o_err  <= r_err;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_char  = r_o_char;
    assign o_rsp.cursor_pos = r_o_pos;
    assign o_rsp.error_flag = r_o_err;

    `TSCB_ASSERT_NOW(a_idle_no_write, i_clk, i_rst_n,
        r_state == S_IDLE, !mem_we, "ram written while idle")
    `TSCB_ASSERT_NOW(a_no_rw_overlap, i_clk, i_rst_n,
        mem_we, !mem_re, "ram read and write in the same cycle")
    `TSCB_ASSERT_NOW(a_square_in_area, i_clk, i_rst_n,
        r_state == S_SQ, r_addr < size_s, "square outline cell outside the area")
    `TSCB_ASSERT_NEXT(a_rsp_loaded, i_clk, i_rst_n,
        load_out, r_out_valid, "response word not presented after read")
endmodule
